FILE: src/wtcm_pkg.sv
`default_nettype none

package wtcm_pkg;

   // Texture, view and fixed-point settings.
   localparam int TEXTURE_WIDTH  = 64;
   localparam int TEXTURE_HEIGHT = 64;
   localparam int VIEW_HEIGHT    = 512;
   localparam int FRACTION_BITS  = 16;

   // Field widths of the two channels.
   localparam int COLUMN_W = 12;
   localparam int POS_IN_W = 24;
   localparam int DIST_W   = 24;
   localparam int DIR_W    = 18;
   localparam int LH_W     = 16;
   localparam int DS_W     = 9;
   localparam int ROW_W    = 10;
   localparam int OUT_ROW_W = 9;
   localparam int TEX_ID_W = 2;
   localparam int TEXEL_W  = 6;

   // Internal widths.
   localparam int FRAC_W     = 2 * FRACTION_BITS;
   localparam int TX_W       = $clog2(TEXTURE_WIDTH);
   localparam int MUL_W      = DIST_W + 1 + DIR_W;
   localparam int STEP_W     = 32;
   localparam int POS_W      = 40;
   localparam int BASE_W     = 18;
   localparam int DIVIDEND   = TEXTURE_HEIGHT * (2 ** FRACTION_BITS);
   localparam int DIVIDEND_W = $clog2(DIVIDEND + 1);
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Wall texture indexes.
   localparam logic [TEX_ID_W-1:0] TEX_Y_NEG = 2'd0;
   localparam logic [TEX_ID_W-1:0] TEX_Y_POS = 2'd1;
   localparam logic [TEX_ID_W-1:0] TEX_X_NEG = 2'd2;
   localparam logic [TEX_ID_W-1:0] TEX_X_POS = 2'd3;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic                        req_type;
      logic [COLUMN_W-1:0]         column_x;
      logic [FRACTION_BITS-1:0]    pos_low;
      logic [DIST_W-1:0]           distance;
      logic signed [DIR_W-1:0]     dir;
      logic [TEX_ID_W-1:0]         texture_id;
      logic                        mirror;
      logic [LH_W-1:0]             slice_height;
      logic [DS_W-1:0]             first_row;
      logic [ROW_W-1:0]            stop_row;
   } wtcm_entry_type;

   // Queue status seen by the two sides.
   typedef struct packed {
      logic not_empty;
      logic full;
   } wtcm_qstat_type;

endpackage

`default_nettype wire

FILE: src/wtcm_if.sv
`default_nettype none

// Column request channel.
interface wtcm_req_if import wtcm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [COLUMN_W-1:0]       column_x;
   logic                      hit_side;
   logic [POS_IN_W-1:0]       player_pos_x;
   logic [POS_IN_W-1:0]       player_pos_y;
   logic [DIST_W-1:0]         wall_dist;
   logic signed [DIR_W-1:0]   ray_dir_x;
   logic signed [DIR_W-1:0]   ray_dir_y;
   logic [LH_W-1:0]           slice_height;
   logic [DS_W-1:0]           first_row;
   logic [ROW_W-1:0]          stop_row;

   modport source (
      output valid, req_type, column_x, hit_side, player_pos_x, player_pos_y,
             wall_dist, ray_dir_x, ray_dir_y, slice_height, first_row, stop_row,
      input  ready
   );
   modport sink (
      input  valid, req_type, column_x, hit_side, player_pos_x, player_pos_y,
             wall_dist, ray_dir_x, ray_dir_y, slice_height, first_row, stop_row,
      output ready
   );
endinterface

// Pixel result channel.
interface wtcm_rsp_if import wtcm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COLUMN_W-1:0]    out_column;
   logic [OUT_ROW_W-1:0]   out_row;
   logic [TEX_ID_W-1:0]    texture_id;
   logic [TEXEL_W-1:0]     texel_x;
   logic [TEXEL_W-1:0]     texel_y;
   logic                   last_in_column;

   modport source (
      output valid, out_column, out_row, texture_id, texel_x, texel_y, last_in_column,
      input  ready
   );
   modport sink (
      input  valid, out_column, out_row, texture_id, texel_x, texel_y, last_in_column,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/wall_texture_column_mapper_top.sv
`default_nettype none

// Textured wall column mapper. A column-start transfer on req_ch sets up one
// wall slice (texture choice, texture column, per-row step and start position)
// and returns nothing; each following pixel transfer within the slice returns
// one result on rsp_ch with the pixel's row and texture coordinates, the last
// one flagged. Pixel transfers flow at one per cycle while rsp_ch is ready. A
// column start holds the back end while it is taken in, while the restoring
// divider forms the texture step one bit per cycle and while the texture
// position is seeded; a two-entry queue takes up to two more requests
// meanwhile, after which req_ch holds ready low until the back end pops again.

module wall_texture_column_mapper_top import wtcm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   wtcm_req_if.sink      req_ch,
   wtcm_rsp_if.source    rsp_ch
);

   wtcm_qstat_type stat;
   wtcm_entry_type push_data;
   wtcm_entry_type head;
   logic           push;
   logic           pop;

   wtcm_front u_front (
      .req_ch    (req_ch),
      .stat      (stat),
      .push      (push),
      .push_data (push_data)
   );

   wtcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   wtcm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .stat   (stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: src/wtcm_queue.sv
`default_nettype none

module wtcm_queue import wtcm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire wtcm_entry_type push_data,
   input  wire logic           pop,
   output wtcm_entry_type      head,
   output wtcm_qstat_type      stat
);

   wtcm_entry_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   // Pointer and fill bookkeeping for the two-entry queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign stat = {(count_ff != 2'd0), (count_ff == 2'd2)};

endmodule

`default_nettype wire

FILE: src/wtcm_front.sv
`default_nettype none

module wtcm_front import wtcm_pkg::*; (
   wtcm_req_if.sink             req_ch,
   input  wire wtcm_qstat_type  stat,
   output logic                 push,
   output wtcm_entry_type       push_data
);

   // Accept whenever the queue has room.
   assign req_ch.ready = !stat.full;
   assign push         = req_ch.valid && !stat.full;

   // Classify the item: pick the texture, the wall axis operands and the mirror.
   always_comb begin
      push_data.req_type     = req_ch.req_type;
      push_data.column_x     = req_ch.column_x;
      push_data.distance     = req_ch.wall_dist;
      push_data.slice_height = req_ch.slice_height;
      push_data.first_row    = req_ch.first_row;
      push_data.stop_row     = req_ch.stop_row;
      if (req_ch.hit_side == 1'b0) begin
         push_data.texture_id = req_ch.ray_dir_x[DIR_W-1] ? TEX_X_NEG : TEX_X_POS;
         push_data.pos_low    = req_ch.player_pos_y[FRACTION_BITS-1:0];
         push_data.dir        = req_ch.ray_dir_y;
         push_data.mirror     = req_ch.ray_dir_x[DIR_W-1];
      end else begin
         push_data.texture_id = req_ch.ray_dir_y[DIR_W-1] ? TEX_Y_NEG : TEX_Y_POS;
         push_data.pos_low    = req_ch.player_pos_x[FRACTION_BITS-1:0];
         push_data.dir        = req_ch.ray_dir_x;
         push_data.mirror     = !req_ch.ray_dir_y[DIR_W-1] && (req_ch.ray_dir_y != '0);
      end
   end

endmodule

`default_nettype wire

FILE: src/wtcm_back.sv
`default_nettype none

module wtcm_back import wtcm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire wtcm_entry_type head,
   input  wire wtcm_qstat_type stat,
   output logic                pop,
   wtcm_rsp_if.source          rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEED
   } state_type;

   state_type                  state_ff, state_in;
   logic                       active_ff, active_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [ROW_W-1:0]           end_ff, end_in;
   logic [COLUMN_W-1:0]        column_ff, column_in;
   logic [TEXEL_W-1:0]         texel_x_ff, texel_x_in;
   logic [TEX_ID_W-1:0]        tex_id_ff, tex_id_in;
   logic                       mirror_ff, mirror_in;
   logic [FRACTION_BITS-1:0]   pos_low_ff, pos_low_in;
   logic [FRAC_W-1:0]          mul_ff, mul_in;
   logic [LH_W-1:0]            lh_ff, lh_in;
   logic [LH_W-1:0]            divisor_ff, divisor_in;
   logic [LH_W-1:0]            rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]       count_ff, count_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0]        rsp_column_ff, rsp_column_in;
   logic [OUT_ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [TEX_ID_W-1:0]        rsp_tex_id_ff, rsp_tex_id_in;
   logic [TEXEL_W-1:0]         rsp_texel_x_ff, rsp_texel_x_in;
   logic [TEXEL_W-1:0]         rsp_texel_y_ff, rsp_texel_y_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic signed [MUL_W-1:0]    hit_prod;
   logic [FRAC_W-1:0]          frac;
   logic [FRAC_W+TX_W-1:0]     scaled;
   logic [TX_W-1:0]            tx_raw;
   logic [TX_W-1:0]            tx;
   logic [LH_W:0]              trial;
   logic                       trial_fits;
   logic signed [BASE_W-1:0]   base;
   logic signed [BASE_W+STEP_W:0] seed_prod;
   logic [ROW_W:0]             next_row;
   logic [ROW_W-1:0]           clip_end;

   // Distance times ray component along the wall; only the fraction bits matter.
   assign hit_prod = $signed({1'b0, head.distance}) * $signed(head.dir);

   // Fraction of the hit point scaled to a texture column, mirrored as needed.
   assign frac   = {pos_low_ff, FRACTION_BITS'(0)} + mul_ff;
   assign scaled = (FRAC_W + TX_W)'(frac) * (FRAC_W + TX_W)'(TEXTURE_WIDTH);
   assign tx_raw = scaled[FRAC_W +: TX_W];
   assign tx     = mirror_ff ? TX_W'(TEXTURE_WIDTH - 1) - tx_raw : tx_raw;

   // One quotient bit per cycle of the restoring divider.
   assign trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_fits = (trial >= {1'b0, divisor_ff});

   // Starting texture position from the slice's first row.
   assign base      = BASE_W'(row_ff) - BASE_W'(VIEW_HEIGHT / 2) + BASE_W'(lh_ff[LH_W-1:1]);
   assign seed_prod = base * $signed({1'b0, STEP_W'(quo_ff)});

   assign next_row = {1'b0, row_ff} + (ROW_W + 1)'(1);
   assign clip_end = (head.stop_row > ROW_W'(VIEW_HEIGHT)) ? ROW_W'(VIEW_HEIGHT)
                                                           : head.stop_row;

   // Next-state logic for the column sequencer and the result register.
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      row_in         = row_ff;
      end_in         = end_ff;
      column_in      = column_ff;
      texel_x_in     = texel_x_ff;
      tex_id_in      = tex_id_ff;
      mirror_in      = mirror_ff;
      pos_low_in     = pos_low_ff;
      mul_in         = mul_ff;
      lh_in          = lh_ff;
      divisor_in     = divisor_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_column_in  = rsp_column_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_tex_id_in  = rsp_tex_id_ff;
      rsp_texel_x_in = rsp_texel_x_ff;
      rsp_texel_y_in = rsp_texel_y_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (stat.not_empty) begin
               if (head.req_type == REQ_START) begin
                  // Column start: drop any running slice and set up the new one.
                  pop        = 1'b1;
                  active_in  = 1'b0;
                  column_in  = head.column_x;
                  tex_id_in  = head.texture_id;
                  mirror_in  = head.mirror;
                  pos_low_in = head.pos_low;
                  mul_in     = hit_prod[FRAC_W-1:0];
                  lh_in      = head.slice_height;
                  divisor_in = (head.slice_height == '0) ? LH_W'(1) : head.slice_height;
                  rem_in     = '0;
                  quo_in     = DIVIDEND_W'(DIVIDEND);
                  count_in   = '0;
                  row_in     = ROW_W'(head.first_row);
                  end_in     = clip_end;
                  state_in   = ST_DIV;
               end else if (!active_ff) begin
                  // Pixel request with no slice open is dropped.
                  pop = 1'b1;
               end else if (!rsp_valid_ff || rsp_ch.ready) begin
                  // Emit one pixel and advance down the slice.
                  pop            = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_column_in  = column_ff;
                  rsp_row_in     = row_ff[OUT_ROW_W-1:0];
                  rsp_tex_id_in  = tex_id_ff;
                  rsp_texel_x_in = texel_x_ff;
                  rsp_texel_y_in = TEXEL_W'(pos_ff[POS_W-1:FRACTION_BITS] &
                                            (POS_W - FRACTION_BITS)'(TEXTURE_HEIGHT - 1));
                  rsp_last_in    = (next_row >= {1'b0, end_ff});
                  pos_in         = pos_ff + POS_W'(step_ff);
                  row_in         = next_row[ROW_W-1:0];
                  if (next_row >= {1'b0, end_ff}) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         ST_DIV: begin
            texel_x_in = TEXEL_W'(tx);
            rem_in     = trial_fits ? LH_W'(trial - {1'b0, divisor_ff}) : LH_W'(trial);
            quo_in     = {quo_ff[DIVIDEND_W-2:0], trial_fits};
            count_in   = count_ff + DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            step_in   = STEP_W'(quo_ff);
            pos_in    = seed_prod[POS_W-1:0];
            active_in = (row_ff < end_ff);
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      pos_ff         <= pos_in;
      step_ff        <= step_in;
      row_ff         <= row_in;
      end_ff         <= end_in;
      column_ff      <= column_in;
      texel_x_ff     <= texel_x_in;
      tex_id_ff      <= tex_id_in;
      mirror_ff      <= mirror_in;
      pos_low_ff     <= pos_low_in;
      mul_ff         <= mul_in;
      lh_ff          <= lh_in;
      divisor_ff     <= divisor_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_tex_id_ff  <= rsp_tex_id_in;
      rsp_texel_x_ff <= rsp_texel_x_in;
      rsp_texel_y_ff <= rsp_texel_y_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_column     = rsp_column_ff;
   assign rsp_ch.out_row        = rsp_row_ff;
   assign rsp_ch.texture_id     = rsp_tex_id_ff;
   assign rsp_ch.texel_x        = rsp_texel_x_ff;
   assign rsp_ch.texel_y        = rsp_texel_y_ff;
   assign rsp_ch.last_in_column = rsp_last_ff;

endmodule

`default_nettype wire

FILE: tb/tb_wall_texture_column_mapper_top.sv
`default_nettype none

module tb_wall_texture_column_mapper_top import wtcm_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int REPORT_LIMIT   = 10;

   // One request as the testbench builds it.
   typedef struct {
      logic                    req_type;
      logic [COLUMN_W-1:0]     column_x;
      logic                    hit_side;
      logic [POS_IN_W-1:0]     player_pos_x;
      logic [POS_IN_W-1:0]     player_pos_y;
      logic [DIST_W-1:0]       wall_dist;
      logic signed [DIR_W-1:0] ray_dir_x;
      logic signed [DIR_W-1:0] ray_dir_y;
      logic [LH_W-1:0]         slice_height;
      logic [DS_W-1:0]         first_row;
      logic [ROW_W-1:0]        stop_row;
   } column_req_type;

   // Texture coordinates of one predicted pixel.
   typedef struct {
      logic [COLUMN_W-1:0]  out_column;
      logic [OUT_ROW_W-1:0] out_row;
      logic [TEX_ID_W-1:0]  texture_id;
      logic [TEXEL_W-1:0]   texel_x;
      logic [TEXEL_W-1:0]   texel_y;
      logic                 last_in_column;
   } texel_pixel_type;

   logic clock = 1'b0;
   logic reset;

   wtcm_req_if req_ch ();
   wtcm_rsp_if rsp_ch ();

   wall_texture_column_mapper_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // Slice state of the predictor.
   logic [POS_W-1:0]    slice_pos;
   logic [STEP_W-1:0]   slice_step;
   logic [ROW_W-1:0]    slice_row;
   logic [ROW_W-1:0]    slice_end;
   logic [COLUMN_W-1:0] slice_column;
   logic [TEXEL_W-1:0]  slice_texel_x;
   logic [TEX_ID_W-1:0] slice_texture;
   logic                slice_live;

   texel_pixel_type pending_pixels[$];

   int idle_pct;
   int stall_left;
   int idle_cycles;
   int mismatches;
   int column_starts;
   int pixels_checked;
   int ignored_steps;
   int useful_items;

   // Column start: texture choice, texture column, step and seed position.
   function automatic void map_column_start(input column_req_type r);
      logic [63:0] hit;
      logic [63:0] frac;
      logic [63:0] col;
      longint      pos_v;
      longint      dist_v;
      longint      dir_v;
      longint      divisor;
      longint      base_v;
      if (r.hit_side == 1'b0) begin
         slice_texture = (r.ray_dir_x < 0) ? TEX_X_NEG : TEX_X_POS;
      end else begin
         slice_texture = (r.ray_dir_y < 0) ? TEX_Y_NEG : TEX_Y_POS;
      end

      // The hit point along the wall runs across the other axis.
      pos_v  = r.hit_side ? r.player_pos_x : r.player_pos_y;
      dir_v  = r.hit_side ? r.ray_dir_x : r.ray_dir_y;
      dist_v = r.wall_dist;
      hit    = (pos_v << FRACTION_BITS) + dist_v * dir_v;
      frac   = hit & ((64'd1 << FRAC_W) - 1);
      col    = (frac * TEXTURE_WIDTH) >> FRAC_W;
      if ((!r.hit_side && r.ray_dir_x < 0) || (r.hit_side && r.ray_dir_y > 0)) begin
         col = TEXTURE_WIDTH - 1 - col;
      end
      slice_texel_x = col[TEXEL_W-1:0];

      // A zero height divides by one.
      divisor    = (r.slice_height == '0) ? 1 : longint'(r.slice_height);
      slice_step = STEP_W'(longint'(DIVIDEND) / divisor);
      base_v     = longint'(r.first_row) - VIEW_HEIGHT / 2 + longint'(r.slice_height) / 2;
      slice_pos  = POS_W'(base_v * longint'(slice_step));

      slice_column = r.column_x;
      slice_row    = ROW_W'(r.first_row);
      slice_end    = (r.stop_row > VIEW_HEIGHT) ? ROW_W'(VIEW_HEIGHT) : r.stop_row;
      slice_live   = slice_row < slice_end;
      column_starts++;
      useful_items++;
   endfunction

   // Pixel step: one result while a slice is live, otherwise nothing.
   function automatic void map_pixel_step();
      texel_pixel_type  px;
      logic [ROW_W-1:0] next_row;
      if (!slice_live) begin
         ignored_steps++;
         return;
      end
      next_row          = slice_row + 1'b1;
      px.out_column     = slice_column;
      px.out_row        = slice_row[OUT_ROW_W-1:0];
      px.texture_id     = slice_texture;
      px.texel_x        = slice_texel_x;
      px.texel_y        = TEXEL_W'((slice_pos >> FRACTION_BITS) & (TEXTURE_HEIGHT - 1));
      px.last_in_column = next_row >= slice_end;
      pending_pixels.push_back(px);
      slice_pos  = slice_pos + POS_W'(slice_step);
      slice_row  = next_row;
      slice_live = !(next_row >= slice_end);
      useful_items++;
   endfunction

   // Random bits of a field, leaning toward the extremes now and then.
   function automatic logic [31:0] rand_bits(input int unsigned w);
      logic [31:0] mask;
      mask = (w >= 32) ? '1 : ((32'd1 << w) - 1);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return mask;
         2: return 32'd1;
         default: return $urandom & mask;
      endcase
   endfunction

   function automatic column_req_type random_item();
      column_req_type r;
      r.req_type     = 1'($urandom_range(0, 1));
      r.column_x     = COLUMN_W'($urandom);
      r.hit_side     = 1'($urandom_range(0, 1));
      r.player_pos_x = POS_IN_W'(rand_bits(POS_IN_W));
      r.player_pos_y = POS_IN_W'(rand_bits(POS_IN_W));
      r.wall_dist    = DIST_W'(rand_bits(DIST_W));
      r.ray_dir_x    = DIR_W'(rand_bits(DIR_W));
      r.ray_dir_y    = DIR_W'(rand_bits(DIR_W));
      r.slice_height = LH_W'(rand_bits(LH_W));
      r.first_row    = DS_W'(rand_bits(DS_W));
      r.stop_row     = ROW_W'(rand_bits(ROW_W));
      return r;
   endfunction

   function automatic column_req_type make_step();
      column_req_type r;
      r          = random_item();
      r.req_type = REQ_STEP;
      return r;
   endfunction

   // Column start with mostly short slices, some long, clipped or empty.
   function automatic column_req_type random_start();
      column_req_type r;
      int             sel;
      r          = random_item();
      r.req_type = REQ_START;
      sel        = $urandom_range(0, 99);
      if (sel < 2) begin
         r.stop_row = ROW_W'($urandom_range(r.first_row, 1023));
      end else if (sel < 10) begin
         r.stop_row = ROW_W'(rand_bits(ROW_W));
      end else if (sel < 25) begin
         r.stop_row = ROW_W'(r.first_row) + ROW_W'($urandom_range(13, 64));
      end else begin
         r.stop_row = ROW_W'(r.first_row) + ROW_W'($urandom_range(1, 12));
      end
      case ($urandom_range(0, 9)) inside
         0: r.slice_height = LH_W'(rand_bits(LH_W));
         [1:4]: r.slice_height = LH_W'($urandom_range(1, 64));
         default: r.slice_height = LH_W'($urandom_range(65, 1200));
      endcase
      return r;
   endfunction

   function automatic column_req_type make_start(
      input logic [COLUMN_W-1:0] column, input logic side,
      input logic [POS_IN_W-1:0] px, input logic [POS_IN_W-1:0] py,
      input logic [DIST_W-1:0] distance,
      input logic signed [DIR_W-1:0] dx, input logic signed [DIR_W-1:0] dy,
      input logic [LH_W-1:0] lh, input logic [DS_W-1:0] ds, input logic [ROW_W-1:0] de);
      column_req_type r;
      r = '{REQ_START, column, side, px, py, distance, dx, dy, lh, ds, de};
      return r;
   endfunction

   // Drive one request and hold it until the transfer happens.
   task automatic send_item(input column_req_type r);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= r.req_type;
      req_ch.column_x     <= r.column_x;
      req_ch.hit_side     <= r.hit_side;
      req_ch.player_pos_x <= r.player_pos_x;
      req_ch.player_pos_y <= r.player_pos_y;
      req_ch.wall_dist    <= r.wall_dist;
      req_ch.ray_dir_x    <= r.ray_dir_x;
      req_ch.ray_dir_y    <= r.ray_dir_y;
      req_ch.slice_height <= r.slice_height;
      req_ch.first_row    <= r.first_row;
      req_ch.stop_row     <= r.stop_row;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every predicted pixel has arrived.
   task automatic wait_pixels_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_step();
      send_item(make_step());
   endtask

   // Zero height, extreme positions and directions, slice clipped at the bottom.
   task automatic test_zero_height_and_clip();
      send_item(make_start(12'hFFF, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                           18'sh20000, 18'sh1FFFF, 16'd0, 9'd509, 10'd1023));
      repeat (4) send_item(make_step());
   endtask

   // Three of four textures, with and without mirroring, single-pixel slices.
   task automatic test_texture_choice();
      send_item(make_start(12'd0, 1'b1, 24'h012345, 24'h000000, 24'h018000,
                           18'sh0C000, 18'sh10000, 16'd1, 9'd0, 10'd1));
      send_item(make_step());
      send_item(make_start(12'd77, 1'b1, 24'hABCDEF, 24'h123456, 24'h00F00F,
                           18'sh3F000, 18'sh3FFFF, 16'hFFFF, 9'd511, 10'd512));
      send_item(make_step());
      send_item(make_start(12'd2048, 1'b0, 24'h000000, 24'h7FFFFF, 24'h000000,
                           18'sh00000, 18'sh00000, 16'd2, 9'd255, 10'd256));
      send_item(make_step());
   endtask

   // Empty slice, then a slice cut short by a new column start.
   task automatic test_empty_and_restart();
      send_item(make_start(12'd300, 1'b0, 24'h040000, 24'h050000, 24'h020000,
                           18'sh08000, 18'sh38000, 16'd100, 9'd300, 10'd300));
      send_item(make_step());
      send_item(make_start(12'd301, 1'b1, 24'h048000, 24'h051234, 24'h033333,
                           18'sh3C000, 18'sh04000, 16'd300, 9'd10, 10'd400));
      repeat (2) send_item(make_step());
      send_item(make_start(12'd302, 1'b0, 24'h0800FF, 24'h0A00FF, 24'h010101,
                           18'sh00001, 18'sh3FFFF, 16'd40, 9'd100, 10'd102));
      repeat (3) send_item(make_step());
   endtask

   // Well-formed slices with random content, mixed with noise and cut slices.
   task automatic test_random_slices(input int target, input int pct);
      column_req_type r;
      int             columns;
      int             clip_end;
      int             pixels;
      int             steps;
      idle_pct = pct;
      columns  = 0;
      while (useful_items < target) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(random_item());
         end else begin
            r = random_start();
            send_item(r);
            clip_end = (r.stop_row > VIEW_HEIGHT) ? VIEW_HEIGHT : r.stop_row;
            pixels   = (r.first_row < clip_end) ? clip_end - r.first_row : 0;
            case ($urandom_range(0, 9))
               0: steps = $urandom_range(0, pixels);
               1: steps = pixels + $urandom_range(1, 2);
               default: steps = pixels;
            endcase
            repeat (steps) send_item(make_step());
            columns++;
            // Alternate stretches with and without idling.
            if (pct > 0 && columns % 20 == 0) begin
               idle_pct = (idle_pct == 0) ? pct : 0;
            end
         end
      end
   endtask

   // Receiver stalls in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check each result transfer, then predict from each request transfer.
   always @(posedge clock) begin : scoreboard
      column_req_type  seen;
      texel_pixel_type want;
      logic            moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("Unexpected pixel: column %0d row %0d", rsp_ch.out_column,
                           rsp_ch.out_row);
               end
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_ch.out_column !== want.out_column ||
                   rsp_ch.out_row !== want.out_row ||
                   rsp_ch.texture_id !== want.texture_id ||
                   rsp_ch.texel_x !== want.texel_x ||
                   rsp_ch.texel_y !== want.texel_y ||
                   rsp_ch.last_in_column !== want.last_in_column) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display({"Pixel mismatch: expected col %0d row %0d tex %0d",
                               " tx %0d ty %0d last %0b"},
                              want.out_column, want.out_row, want.texture_id, want.texel_x,
                              want.texel_y, want.last_in_column);
                     $display({"                actual   col %0d row %0d tex %0d",
                               " tx %0d ty %0d last %0b"},
                              rsp_ch.out_column, rsp_ch.out_row, rsp_ch.texture_id,
                              rsp_ch.texel_x, rsp_ch.texel_y, rsp_ch.last_in_column);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            seen  = '{req_ch.req_type, req_ch.column_x, req_ch.hit_side,
                      req_ch.player_pos_x, req_ch.player_pos_y, req_ch.wall_dist,
                      req_ch.ray_dir_x, req_ch.ray_dir_y,
                      req_ch.slice_height, req_ch.first_row, req_ch.stop_row};
            if (seen.req_type == REQ_START) begin
               map_column_start(seen);
            end else begin
               map_pixel_step();
            end
         end

         // Watchdog on cycles without any transfer.
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d pixels outstanding",
                     WATCHDOG_LIMIT, pending_pixels.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_STEP;
      req_ch.column_x     = '0;
      req_ch.hit_side     = 1'b0;
      req_ch.player_pos_x = '0;
      req_ch.player_pos_y = '0;
      req_ch.wall_dist    = '0;
      req_ch.ray_dir_x    = '0;
      req_ch.ray_dir_y    = '0;
      req_ch.slice_height = '0;
      req_ch.first_row    = '0;
      req_ch.stop_row     = '0;
      rsp_ch.ready        = 1'b0;
      idle_pct            = 0;
      stall_left          = 0;
      idle_cycles         = 0;
      mismatches          = 0;
      column_starts       = 0;
      pixels_checked      = 0;
      ignored_steps       = 0;
      useful_items        = 0;
      slice_pos           = '0;
      slice_step          = '0;
      slice_row           = '0;
      slice_end           = '0;
      slice_column        = '0;
      slice_texel_x       = '0;
      slice_texture       = '0;
      slice_live          = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 30;
      test_idle_step();
      test_zero_height_and_clip();
      test_texture_choice();
      test_empty_and_restart();
      wait_pixels_drained();

      test_random_slices(1450, 25);
      test_random_slices(1700, 0);

      wait_pixels_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_pixels.size() != 0) begin
         $display("%0d predicted pixels never arrived", pending_pixels.size());
      end
      $display("Run covered %0d column starts, %0d checked pixels, %0d steps outside a slice.",
               column_starts, pixels_checked, ignored_steps);
      $display("Slices were clipped, empty, cut short or zero height, with and without stalls.");
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
